// ===== hdl/aes_pkg.sv =====
// Shared constants, S-box table and GF(2^8) helpers for the AES-128 block encrypt unit.
package aes_pkg;

  localparam int MIDDLE_ROUNDS_DEFAULT = 9;

  localparam int BLOCK_W = 128;
  localparam int HALF_W  = 64;
  localparam int IDX_W   = 4;

  // Kind codes carried on the input tuser
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Column bytes a0..a3 from the top bit down
  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

// ===== hdl/aes128_block_encrypt_unit.sv =====
// Top level of the AES-128 block encrypt unit: sequencer, state and output registers.
//
// Input channel s_axis: tuser is the kind (0 = load round key, 1 = encrypt block).
// A key transaction writes slot round_index of the key store and
// returns nothing; an index at or above MIDDLE_ROUNDS+2 is dropped. Load every
// slot before encrypting. A block transaction returns one ciphertext on m_axis.
// An encryption applies round key 0 in the cycle of acceptance, then steps
// through rounds 1 to MIDDLE_ROUNDS+1 in the single shared round unit, whose
// key comes from the one read port of the key store.
// tready is low while a block is in the rounds; the next transaction is taken
// in the cycle after the last round; no block enters before the last is done.
// Ciphertext sits in an output register; a new block may be accepted while it
// waits. If the receiver still stalls when the next block finishes, the final
// round holds until the register frees.
// Reset (rst, synchronous) clears the sequencer and the output valid; the key
// store keeps its content and is undefined until written.
module aes128_block_encrypt_unit #(
  parameter int MIDDLE_ROUNDS = aes_pkg::MIDDLE_ROUNDS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] round_index, [67:4] data_hi, [131:68] data_lo, [135:132] zero
  input  logic [135:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] cipher_hi, [127:64] cipher_lo
  output logic [127:0] m_axis_tdata
);

  localparam int KEY_SLOTS = MIDDLE_ROUNDS + 2;
  localparam int KEY_AW    = $clog2(KEY_SLOTS);
  localparam logic [KEY_AW-1:0] LAST_ROUND = KEY_AW'(MIDDLE_ROUNDS + 1);
  localparam logic [KEY_AW-1:0] FIRST_ROUND = KEY_AW'(1);
  localparam logic [KEY_AW-1:0] KEY0 = '0;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state;
  logic [KEY_AW-1:0]           rnd;
  logic [aes_pkg::BLOCK_W-1:0] blk;
  logic                        out_valid;
  logic [aes_pkg::BLOCK_W-1:0] out_data;

  logic [aes_pkg::IDX_W-1:0]   round_index;
  logic [aes_pkg::HALF_W-1:0]  data_hi;
  logic [aes_pkg::HALF_W-1:0]  data_lo;
  logic                        kind;

  logic                        accept;
  logic                        start;
  logic                        key_we;
  logic                        last;
  logic                        advance;
  logic [KEY_AW-1:0]           rd_addr;
  logic [aes_pkg::BLOCK_W-1:0] key_rd;
  logic [aes_pkg::BLOCK_W-1:0] round_out;

  assign round_index = s_axis_tdata[3:0];
  assign data_hi     = s_axis_tdata[67:4];
  assign data_lo     = s_axis_tdata[131:68];
  assign kind        = s_axis_tuser[0];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && (kind == aes_pkg::KIND_BLOCK);
  assign key_we        = accept && (kind == aes_pkg::KIND_KEY)
                         && (32'(round_index) < KEY_SLOTS);
  assign last          = (rnd == LAST_ROUND);
  // Hold the final round while an untaken result still fills the output register
  assign advance       = (state == ST_RUN) && (!last || !out_valid || m_axis_tready);

  // Fetch one key ahead; park on key 0 while idle
  always_comb begin
    if (state == ST_RUN) begin
      if (advance) begin
        rd_addr = last ? KEY0 : rnd + KEY_AW'(1);
      end else begin
        rd_addr = rnd;
      end
    end else begin
      rd_addr = start ? FIRST_ROUND : KEY0;
    end
  end

  aes_key_store #(
    .KEY_SLOTS (KEY_SLOTS),
    .KEY_AW    (KEY_AW)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (KEY_AW'(round_index)),
    .wr_data ({data_hi, data_lo}),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  aes_round u_round (
    .state_in  (blk),
    .round_key (key_rd),
    .last      (last),
    .state_out (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= KEY0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            rnd   <= FIRST_ROUND;
          end
        end
        ST_RUN: begin
          if (advance) begin
            if (last) begin
              state <= ST_IDLE;
              rnd   <= KEY0;
            end else begin
              rnd <= rnd + KEY_AW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          rnd   <= KEY0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      blk <= {data_hi, data_lo} ^ key_rd;
    end else if (advance) begin
      blk <= round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      out_data <= round_out;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_data[63:0], out_data[127:64]};

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_RUN) && (rnd == FIRST_ROUND))
    else $error("encryption did not enter the first round");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    (advance && last) |=> out_valid && (state == ST_IDLE))
    else $error("finished block not presented on the output");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && last && out_valid && !m_axis_tready)
      |=> (state == ST_RUN) && last && $stable(blk))
    else $error("final round advanced over an untaken result");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rnd != KEY0) && (32'(rnd) <= MIDDLE_ROUNDS + 1))
    else $error("round counter out of range");

endmodule

// ===== hdl/aes_key_store.sv =====
// Round key memory: one write port, one registered write-first read port.
module aes_key_store #(
  parameter int KEY_SLOTS = aes_pkg::MIDDLE_ROUNDS_DEFAULT + 2,
  parameter int KEY_AW    = $clog2(KEY_SLOTS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [KEY_AW-1:0]            wr_addr,
  input  logic [aes_pkg::BLOCK_W-1:0]  wr_data,
  input  logic [KEY_AW-1:0]            rd_addr,
  output logic [aes_pkg::BLOCK_W-1:0]  rd_data
);

  logic [aes_pkg::BLOCK_W-1:0] mem [KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward a same-cycle write so a key is readable on the next cycle
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/aes_round.sv =====
// Shared round datapath: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round (
  input  logic [aes_pkg::BLOCK_W-1:0] state_in,
  input  logic [aes_pkg::BLOCK_W-1:0] round_key,
  input  logic                        last,
  output logic [aes_pkg::BLOCK_W-1:0] state_out
);

  logic [7:0]  st [16];
  logic [7:0]  sh [16];
  logic [31:0] mixed [4];
  logic [aes_pkg::BLOCK_W-1:0] pre_key;

  // Bytes are column-major: byte 4*c + r sits in column c, row r
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      st[i] = state_in[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[4*c + r] = aes_pkg::SBOX[st[4*((c + r) & 3) + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mixed[c] = aes_pkg::mix_column({sh[4*c], sh[4*c + 1], sh[4*c + 2], sh[4*c + 3]});
    end
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        pre_key[127 - 32*c -: 32] = {sh[4*c], sh[4*c + 1], sh[4*c + 2], sh[4*c + 3]};
      end else begin
        pre_key[127 - 32*c -: 32] = mixed[c];
      end
    end
    state_out = pre_key ^ round_key;
  end

endmodule
